FILE: rtl/t2u_pkg.sv
// ----------------------------------------------------------------------------
// t2u_pkg: shared types, constants and functions for the text to UTF-8 block
// Holds register indexes, the Windows-1252 upper table and the run record.
// ----------------------------------------------------------------------------
`default_nettype none

package t2u_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SOURCE_MODE = 2'd0;
  localparam logic [1:0] REG_BYTE_BUDGET = 2'd1;

  // Source modes
  localparam logic MODE_WIDE   = 1'b0;
  localparam logic MODE_CP1252 = 1'b1;

  // Budget limits
  localparam logic [11:0] BUDGET_MAX   = 12'd4095;
  localparam logic [11:0] BUDGET_RESET = 12'd4095;

  // UTF-8 lead and continuation marks
  localparam logic [7:0]  LEAD2      = 8'hC0;
  localparam logic [7:0]  LEAD3      = 8'hE0;
  localparam logic [7:0]  CONT       = 8'h80;
  localparam logic [15:0] CP_REPLACE = 16'hFFFD;
  localparam logic [15:0] CP_EURO    = 16'h20AC;
  localparam logic [15:0] LIM_ONE    = 16'h0080;
  localparam logic [15:0] LIM_TWO    = 16'h0800;
  localparam logic [7:0]  C1_LOW     = 8'h80;
  localparam logic [7:0]  C1_HIGH    = 8'hA0;

  // Encoded character, before the budget decision
  typedef struct packed {
    logic            term;
    logic [1:0]      len;
    logic [2:0][7:0] bytes;
  } enc_t;

  // Bytes loaded into the output buffer for one request
  typedef struct packed {
    logic [1:0]      cnt;
    logic            term;
    logic [2:0][7:0] bytes;
  } run_t;

  // Clamp a budget value to the allowed maximum
  function automatic logic [11:0] budget_clamp(input logic [11:0] v);
    budget_clamp = (v > BUDGET_MAX) ? BUDGET_MAX : v;
  endfunction

  // Map Windows-1252 bytes 0x80..0x9F to code points
  function automatic logic [15:0] cp1252_map(input logic [4:0] idx);
    logic [15:0] cp;
    cp = CP_REPLACE;
    case (idx)
      5'd0:  cp = CP_EURO;
      5'd2:  cp = 16'h201A;
      5'd3:  cp = 16'h0192;
      5'd4:  cp = 16'h201E;
      5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020;
      5'd7:  cp = 16'h2021;
      5'd8:  cp = 16'h02C6;
      5'd9:  cp = 16'h2030;
      5'd10: cp = 16'h0160;
      5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152;
      5'd14: cp = 16'h017D;
      5'd17: cp = 16'h2018;
      5'd18: cp = 16'h2019;
      5'd19: cp = 16'h201C;
      5'd20: cp = 16'h201D;
      5'd21: cp = 16'h2022;
      5'd22: cp = 16'h2013;
      5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02DC;
      5'd25: cp = 16'h2122;
      5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203A;
      5'd28: cp = 16'h0153;
      5'd30: cp = 16'h017E;
      5'd31: cp = 16'h0178;
      default: cp = CP_REPLACE;
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/t2u_encode.sv
// ----------------------------------------------------------------------------
// t2u_encode: code unit to UTF-8 byte sequence
// Maps the source unit to a code point and splits it into one to three bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module t2u_encode (
  input  wire logic          mode_i,
  input  wire logic [15:0]   code_unit_i,
  input  wire logic          end_of_string_i,
  output t2u_pkg::enc_t      enc_o
);
  import t2u_pkg::*;

  logic [7:0]  low_b;
  logic [15:0] cp;
  logic        zero;

  // Pick the code point for the current mode
  always_comb begin
    low_b = code_unit_i[7:0];
    if (mode_i == MODE_CP1252) begin
      zero = (low_b == 8'd0);
      if (low_b < C1_LOW) begin
        cp = {8'd0, low_b};
      end else if (low_b < C1_HIGH) begin
        cp = cp1252_map(low_b[4:0]);
      end else begin
        cp = {8'd0, low_b};
      end
    end else begin
      zero = (code_unit_i == 16'd0);
      cp   = code_unit_i;
    end
  end

  // Split into UTF-8 bytes, first byte in slot 0
  always_comb begin
    enc_o.term  = end_of_string_i | zero;
    enc_o.bytes = '0;
    if (cp < LIM_ONE) begin
      enc_o.len      = 2'd1;
      enc_o.bytes[0] = cp[7:0];
    end else if (cp < LIM_TWO) begin
      enc_o.len      = 2'd2;
      enc_o.bytes[0] = LEAD2 | {3'd0, cp[10:6]};
      enc_o.bytes[1] = CONT | {2'd0, cp[5:0]};
    end else begin
      enc_o.len      = 2'd3;
      enc_o.bytes[0] = LEAD3 | {4'd0, cp[15:12]};
      enc_o.bytes[1] = CONT | {2'd0, cp[11:6]};
      enc_o.bytes[2] = CONT | {2'd0, cp[5:0]};
    end
    if (enc_o.term) begin
      enc_o.bytes[0] = 8'd0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/t2u_ctrl.sv
// ----------------------------------------------------------------------------
// t2u_ctrl: configuration registers and byte budget tracking
// Holds the mode and budget, counts data bytes down and halts on overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module t2u_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [11:0]   cfg_data_i,
  input  wire logic          accept_i,
  input  wire t2u_pkg::enc_t enc_i,
  output logic               mode_o,
  output logic               emit_o
);
  import t2u_pkg::*;

  logic        mode_q, mode_d;
  logic [11:0] budget_q, budget_d;
  logic [11:0] left_q, left_d;
  logic        halted_q, halted_d;
  logic        fits;

  assign mode_o = mode_q;
  assign fits   = ({10'd0, enc_i.len} <= left_q);
  assign emit_o = !enc_i.term && !halted_q && fits;

  // Update registers on configuration writes and accepted requests
  always_comb begin
    mode_d   = mode_q;
    budget_d = budget_q;
    left_d   = left_q;
    halted_d = halted_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SOURCE_MODE: mode_d = cfg_data_i[0];
        REG_BYTE_BUDGET: begin
          budget_d = cfg_data_i;
          left_d   = budget_clamp(cfg_data_i);
        end
        default: ;
      endcase
    end
    if (accept_i) begin
      if (enc_i.term) begin
        left_d   = budget_clamp(budget_q);
        halted_d = 1'b0;
      end else if (!halted_q) begin
        if (fits) begin
          left_d = left_q - {10'd0, enc_i.len};
        end else begin
          halted_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_WIDE;
      budget_q <= BUDGET_RESET;
      left_q   <= budget_clamp(BUDGET_RESET);
      halted_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      budget_q <= budget_d;
      left_q   <= left_d;
      halted_q <= halted_d;
    end
  end

  // A character that overflows the budget halts output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !cfg_we_i && !enc_i.term && !halted_q && !fits) |=> halted_q)
    else $error("t2u_ctrl: overflow did not halt");

  // A terminator clears halt and reloads the budget
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !cfg_we_i && enc_i.term) |=>
      (!halted_q && left_q == budget_clamp(budget_q)))
    else $error("t2u_ctrl: terminator did not reload budget");

endmodule

`default_nettype wire

FILE: rtl/t2u_outbuf.sv
// ----------------------------------------------------------------------------
// t2u_outbuf: result register and byte serializer
// Holds one request's bytes, up to three; shifts one out per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module t2u_outbuf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire t2u_pkg::run_t run_i,
  output logic               load_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o,
  output logic               is_terminator_o
);
  import t2u_pkg::*;

  logic [1:0]      cnt_q, cnt_d;
  logic            term_q, term_d;
  logic [2:0][7:0] bytes_q, bytes_d;
  logic            pop;

  assign out_valid_o     = (cnt_q != 2'd0);
  assign pop             = out_valid_o && !out_stall_i;
  assign load_ready_o    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall_i);
  assign out_byte_o      = bytes_q[0];
  assign last_of_run_o   = (cnt_q == 2'd1);
  assign is_terminator_o = term_q;

  // Load a new run, or advance through the current one
  always_comb begin
    cnt_d   = cnt_q;
    term_d  = term_q;
    bytes_d = bytes_q;
    if (load_i) begin
      cnt_d   = run_i.cnt;
      term_d  = run_i.term;
      bytes_d = run_i.bytes;
    end else if (pop) begin
      cnt_d      = cnt_q - 2'd1;
      bytes_d[0] = bytes_q[1];
      bytes_d[1] = bytes_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      term_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      term_q <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  // A terminator is always a run of exactly one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (term_q && cnt_q != 2'd0) |-> (cnt_q == 2'd1 && bytes_q[0] == 8'd0))
    else $error("t2u_outbuf: terminator run malformed");

  // A taken byte inside a run moves the count down by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q > 2'd1) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("t2u_outbuf: run count did not advance");

endmodule

`default_nettype wire

FILE: rtl/text_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// text_to_utf8_transcoder: code unit stream to UTF-8 byte stream
// Encodes wide or Windows-1252 characters under a per-string byte budget.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one code unit and an
//   end-of-string flag per request. Output channel (out_valid_o /
//   out_stall_i) delivers one byte per request, with last_of_run_o on the
//   final byte of a character and is_terminator_o on the zero byte that
//   ends a string. The configuration channel (cfg_valid_i / cfg_ready_o)
//   writes source_mode (index 0) or byte_budget (index 1); it is always
//   ready and should be used only while the block is idle.
//   The first byte of a character is registered and appears in the cycle
//   after the input is taken. While out_stall_i is low, the output serializer
//   sends one byte per cycle and keeps a character until all its bytes go;
//   one-byte characters stream at one per cycle, dropped ones load no bytes.
//   Reset clears the output buffer, selects wide mode and loads a budget of
//   4095 bytes. While the receiver stalls, the current byte holds and the
//   input stalls once the buffer cannot drain in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_utf8_transcoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        end_of_string_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o,
  output logic             is_terminator_o
);
  import t2u_pkg::*;

  logic  mode;
  logic  emit;
  logic  load_ready;
  logic  accept;
  enc_t  enc;
  run_t  run;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !load_ready;
  assign accept      = in_valid_i && load_ready;

  t2u_encode u_encode (
    .mode_i          (mode),
    .code_unit_i     (code_unit_i),
    .end_of_string_i (end_of_string_i),
    .enc_o           (enc)
  );

  t2u_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .enc_i       (enc),
    .mode_o      (mode),
    .emit_o      (emit)
  );

  // Build the run: terminator alone, encoded bytes, or nothing
  always_comb begin
    run.term  = enc.term;
    run.bytes = enc.bytes;
    if (enc.term) begin
      run.cnt = 2'd1;
    end else if (emit) begin
      run.cnt = enc.len;
    end else begin
      run.cnt = 2'd0;
    end
  end

  t2u_outbuf u_outbuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .run_i           (run),
    .load_ready_o    (load_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .is_terminator_o (is_terminator_o)
  );

endmodule

`default_nettype wire
